/* src/fcr_pkg.sv */
// Types and constants shared by the framed command receiver.
package fcr_pkg;

  // Framing bytes
  localparam logic [7:0] SYNC_A = 8'h23;
  localparam logic [7:0] SYNC_B = 8'h25;

  // Command headers
  localparam logic [7:0] HDR_NOP       = 8'h00;
  localparam logic [7:0] HDR_SERVO     = 8'h0B;
  localparam logic [7:0] HDR_NIBBLE    = 8'h0C;
  localparam logic [7:0] HDR_PING      = 8'h0D;
  localparam logic [7:0] HDR_DIGITAL   = 8'h82;
  localparam logic [7:0] HDR_ANALOG    = 8'h83;
  localparam logic [7:0] HDR_PONG      = 8'h84;
  localparam logic [7:0] HDR_SHUT_SET  = 8'h20;
  localparam logic [7:0] HDR_SHUT_OPEN = 8'h21;
  localparam logic [7:0] HDR_SHUT_SHUT = 8'h22;

  // Operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Frame phases
  localparam logic [1:0] PH_SYNC    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_CHECK   = 2'd3;

  // Reset values and the servo compare offset
  localparam logic [11:0] CLOSE_LIMIT_RST = 12'd2048;
  localparam logic [7:0]  SHUTTER_POS_RST = 8'd30;
  localparam logic [9:0]  SERVO_RST       = 10'd290;
  localparam logic [9:0]  SERVO_OFFSET    = 10'd230;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
    logic [7:0] digital_inputs;
    logic       shutter_sense;
    logic [9:0] analog_0;
    logic [9:0] analog_1;
    logic [9:0] analog_2;
    logic [9:0] analog_3;
    logic [9:0] analog_4;
    logic [9:0] analog_5;
    logic [9:0] analog_6;
    logic [9:0] analog_7;
  } in_word_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic [9:0]  servo0_compare;
    logic [9:0]  servo1_compare;
    logic [3:0]  output_nibble;
    logic [15:0] checksum_error_count;
    logic [15:0] invalid_header_count;
  } out_word_t;

  // One item's complete result: optional reply frame plus status snapshot
  typedef struct packed {
    logic        reply;
    logic [7:0]  hdr;
    logic [7:0]  d0;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [7:0]  d3;
    logic [7:0]  sum;
    logic [9:0]  servo0;
    logic [9:0]  servo1;
    logic [3:0]  nibble;
    logic [15:0] bad_sum;
    logic [15:0] bad_hdr;
  } result_t;

endpackage

/* src/framed_command_receiver_top.sv */
// Framed command receiver: frame parser, command dispatch and reply serialiser.
//
// Input channel (in_valid/in_stall/in_data) takes one word per item: either a
// received serial byte or an idle tick for the shutter monitor. Frames are
// '#','%', header, four payload bytes and an additive checksum byte.
// Output channel (out_valid/out_stall/out_data) gives one word per plain item
// and eight words for an item that sends a reply frame; last marks the final
// word of each item. Every word carries the servo, nibble and error counts as
// they stand after that item.
// An accepted item is held in the result register and then loaded into the serialiser
// register before its first word reaches the output.
// Throughput: one item per cycle while no replies are sent and out_stall is low; a
// reply occupies the output for its eight words, from the one-byte-per-cycle serialiser while out_stall is low.
// A result register sits between the parser and the serialiser, so one more
// item is taken while the serialiser still waits on a stalled receiver; after
// that in_stall rises until the result register moves on.
// Reset (rst_n low, synchronous) returns the parser to hunting for '#','%',
// clears counters and queues, and restores servos and shutter positions.
// cfg_wr_en writes the shutter close limit (idle ticks, reset 2048).
module framed_command_receiver_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fcr_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fcr_pkg::out_word_t out_data,
  input  logic               cfg_wr_en,
  input  logic [11:0]        cfg_wr_data
);

  function automatic logic [9:0] servo_cmp(input logic [7:0] v);
    servo_cmp = {1'b0, v, 1'b0} + fcr_pkg::SERVO_OFFSET;
  endfunction

  // Configuration and parser state
  logic [11:0] close_limit_r;
  logic [7:0]  prior_byte_r,  prior_byte_nxt;
  logic [1:0]  phase_r,       phase_nxt;
  logic [7:0]  header_r,      header_nxt;
  logic [7:0]  payload_r [4];
  logic        pay_wr;
  logic [2:0]  pay_idx_r,     pay_idx_nxt;
  logic [7:0]  run_sum_r,     run_sum_nxt;
  logic [7:0]  shut_pos_r [4];
  logic        shut_wr;
  logic [9:0]  servo0_r,      servo0_nxt;
  logic [9:0]  servo1_r,      servo1_nxt;
  logic [3:0]  nibble_r,      nibble_nxt;
  logic [15:0] bad_sum_r,     bad_sum_nxt;
  logic [15:0] bad_hdr_r,     bad_hdr_nxt;
  logic [12:0] closed_ticks_r, closed_ticks_nxt;
  logic        closed_flag_r, closed_flag_nxt;

  // Reply build
  logic        rep_en;
  logic [7:0]  rep_hdr, rep_d0, rep_d1, rep_d2, rep_d3, rep_sum;
  logic [9:0]  analog_sel;
  logic        p0_in_range;

  // Result and serialiser registers
  fcr_pkg::result_t res_r, ser_r, res_nxt;
  logic        res_valid_r, ser_valid_r;
  logic [2:0]  ser_idx_r;
  logic        in_acc, out_acc, out_last, res_move;

  assign out_last = !ser_r.reply || (ser_idx_r == 3'd7);
  assign out_acc  = ser_valid_r && !out_stall;
  assign res_move = res_valid_r && (!ser_valid_r || (out_acc && out_last));
  assign in_stall = res_valid_r && !res_move;
  assign in_acc   = in_valid && !in_stall;

  assign p0_in_range = (payload_r[0][7:3] == 5'd0);

  // Pick the analog channel named by the first payload byte
  always_comb begin
    case (payload_r[0][2:0])
      3'd0:    analog_sel = in_data.analog_0;
      3'd1:    analog_sel = in_data.analog_1;
      3'd2:    analog_sel = in_data.analog_2;
      3'd3:    analog_sel = in_data.analog_3;
      3'd4:    analog_sel = in_data.analog_4;
      3'd5:    analog_sel = in_data.analog_5;
      3'd6:    analog_sel = in_data.analog_6;
      default: analog_sel = in_data.analog_7;
    endcase
    if (!p0_in_range) begin
      analog_sel = 10'd0;
    end
  end

  // Parse the word, dispatch finished frames and run the shutter debounce
  always_comb begin
    prior_byte_nxt   = prior_byte_r;
    phase_nxt        = phase_r;
    header_nxt       = header_r;
    pay_wr           = 1'b0;
    pay_idx_nxt      = pay_idx_r;
    run_sum_nxt      = run_sum_r;
    shut_wr          = 1'b0;
    servo0_nxt       = servo0_r;
    servo1_nxt       = servo1_r;
    nibble_nxt       = nibble_r;
    bad_sum_nxt      = bad_sum_r;
    bad_hdr_nxt      = bad_hdr_r;
    closed_ticks_nxt = closed_ticks_r;
    closed_flag_nxt  = closed_flag_r;
    rep_en           = 1'b0;
    rep_hdr          = 8'd0;
    rep_d0           = 8'd0;
    rep_d1           = 8'd0;
    rep_d2           = 8'd0;
    rep_d3           = 8'd0;

    if (in_data.operation == fcr_pkg::OP_BYTE) begin
      prior_byte_nxt = in_data.rx_byte;
      if (prior_byte_r == fcr_pkg::SYNC_A && in_data.rx_byte == fcr_pkg::SYNC_B) begin
        // Start pair restarts the frame anywhere
        phase_nxt   = fcr_pkg::PH_HEADER;
        run_sum_nxt = fcr_pkg::SYNC_A + fcr_pkg::SYNC_B;
      end else begin
        unique case (phase_r)
          fcr_pkg::PH_HEADER: begin
            header_nxt  = in_data.rx_byte;
            run_sum_nxt = run_sum_r + in_data.rx_byte;
            pay_idx_nxt = 3'd0;
            phase_nxt   = fcr_pkg::PH_PAYLOAD;
          end
          fcr_pkg::PH_PAYLOAD: begin
            pay_wr      = 1'b1;
            run_sum_nxt = run_sum_r + in_data.rx_byte;
            pay_idx_nxt = pay_idx_r + 3'd1;
            if (pay_idx_nxt[2]) begin
              phase_nxt = fcr_pkg::PH_CHECK;
            end
          end
          fcr_pkg::PH_CHECK: begin
            phase_nxt = fcr_pkg::PH_SYNC;
            if (run_sum_r != in_data.rx_byte) begin
              bad_sum_nxt = bad_sum_r + 16'd1;
            end else begin
              unique case (header_r)
                fcr_pkg::HDR_NOP: ;
                fcr_pkg::HDR_SERVO: begin
                  if (payload_r[0] == 8'd0) begin
                    servo0_nxt = servo_cmp(payload_r[1]);
                  end else if (payload_r[0] == 8'd1) begin
                    servo1_nxt = servo_cmp(payload_r[1]);
                  end
                end
                fcr_pkg::HDR_NIBBLE: begin
                  if (payload_r[0] == 8'd1) begin
                    nibble_nxt = payload_r[1][3:0];
                  end
                end
                fcr_pkg::HDR_PING: begin
                  rep_en  = 1'b1;
                  rep_hdr = fcr_pkg::HDR_PONG;
                  rep_d0  = 8'h50;
                  rep_d1  = 8'h4F;
                  rep_d2  = 8'h4E;
                  rep_d3  = 8'h47;
                end
                fcr_pkg::HDR_DIGITAL: begin
                  rep_en  = 1'b1;
                  rep_hdr = fcr_pkg::HDR_DIGITAL;
                  rep_d0  = payload_r[0];
                  rep_d1  = {7'd0, p0_in_range & in_data.digital_inputs[payload_r[0][2:0]]};
                end
                fcr_pkg::HDR_ANALOG: begin
                  rep_en  = 1'b1;
                  rep_hdr = fcr_pkg::HDR_ANALOG;
                  rep_d0  = payload_r[0];
                  rep_d1  = analog_sel[7:0];
                  rep_d2  = {6'd0, analog_sel[9:8]};
                end
                fcr_pkg::HDR_SHUT_SET: shut_wr = 1'b1;
                fcr_pkg::HDR_SHUT_OPEN: begin
                  servo0_nxt = servo_cmp(shut_pos_r[0]);
                  servo1_nxt = servo_cmp(shut_pos_r[2]);
                end
                fcr_pkg::HDR_SHUT_SHUT: begin
                  servo0_nxt = servo_cmp(shut_pos_r[1]);
                  servo1_nxt = servo_cmp(shut_pos_r[3]);
                end
                default: bad_hdr_nxt = bad_hdr_r + 16'd1;
              endcase
            end
          end
          default: ;
        endcase
      end
    end else begin
      // Idle tick: debounce the shutter sense
      if (in_data.shutter_sense) begin
        closed_ticks_nxt = 13'd0;
        if (closed_flag_r) begin
          closed_flag_nxt = 1'b0;
          rep_en  = 1'b1;
          rep_hdr = fcr_pkg::HDR_DIGITAL;
          rep_d0  = 8'd1;
          rep_d1  = 8'd1;
        end
      end else if (closed_ticks_r > {1'b0, close_limit_r}) begin
        closed_flag_nxt = 1'b1;
      end else begin
        closed_ticks_nxt = closed_ticks_r + 13'd1;
      end
    end

    rep_sum = fcr_pkg::SYNC_A + fcr_pkg::SYNC_B + rep_hdr + rep_d0 + rep_d1 + rep_d2 + rep_d3;
  end

  // Assemble the item's result
  always_comb begin
    res_nxt.reply   = rep_en;
    res_nxt.hdr     = rep_hdr;
    res_nxt.d0      = rep_d0;
    res_nxt.d1      = rep_d1;
    res_nxt.d2      = rep_d2;
    res_nxt.d3      = rep_d3;
    res_nxt.sum     = rep_sum;
    res_nxt.servo0  = servo0_nxt;
    res_nxt.servo1  = servo1_nxt;
    res_nxt.nibble  = nibble_nxt;
    res_nxt.bad_sum = bad_sum_nxt;
    res_nxt.bad_hdr = bad_hdr_nxt;
  end

  // Hold the close limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_limit_r <= fcr_pkg::CLOSE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      close_limit_r <= cfg_wr_data;
    end
  end

  // Advance parser and command state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_byte_r   <= 8'd0;
      phase_r        <= fcr_pkg::PH_SYNC;
      pay_idx_r      <= 3'd0;
      run_sum_r      <= 8'd0;
      servo0_r       <= fcr_pkg::SERVO_RST;
      servo1_r       <= fcr_pkg::SERVO_RST;
      nibble_r       <= 4'd0;
      bad_sum_r      <= 16'd0;
      bad_hdr_r      <= 16'd0;
      closed_ticks_r <= 13'd0;
      closed_flag_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        shut_pos_r[i] <= fcr_pkg::SHUTTER_POS_RST;
      end
    end else if (in_acc) begin
      prior_byte_r   <= prior_byte_nxt;
      phase_r        <= phase_nxt;
      pay_idx_r      <= pay_idx_nxt;
      run_sum_r      <= run_sum_nxt;
      servo0_r       <= servo0_nxt;
      servo1_r       <= servo1_nxt;
      nibble_r       <= nibble_nxt;
      bad_sum_r      <= bad_sum_nxt;
      bad_hdr_r      <= bad_hdr_nxt;
      closed_ticks_r <= closed_ticks_nxt;
      closed_flag_r  <= closed_flag_nxt;
      if (shut_wr) begin
        for (int i = 0; i < 4; i++) begin
          shut_pos_r[i] <= payload_r[i];
        end
      end
    end
  end

  // Header and payload bytes: written before read, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      header_r <= header_nxt;
      if (pay_wr) begin
        payload_r[pay_idx_r[1:0]] <= in_data.rx_byte;
      end
    end
  end

  // Result register between parser and serialiser
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (in_acc) begin
      res_valid_r <= 1'b1;
    end else if (res_move) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  // Serialiser: drop finished items, step through reply bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      ser_idx_r   <= 3'd0;
    end else if (res_move) begin
      ser_valid_r <= 1'b1;
      ser_idx_r   <= 3'd0;
    end else if (out_acc) begin
      if (out_last) begin
        ser_valid_r <= 1'b0;
        ser_idx_r   <= 3'd0;
      end else begin
        ser_idx_r <= ser_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_move) begin
      ser_r <= res_r;
    end
  end

  // Drive the output word
  always_comb begin
    out_valid                     = ser_valid_r;
    out_data.tx_valid             = ser_r.reply;
    out_data.last                 = out_last;
    out_data.servo0_compare       = ser_r.servo0;
    out_data.servo1_compare       = ser_r.servo1;
    out_data.output_nibble        = ser_r.nibble;
    out_data.checksum_error_count = ser_r.bad_sum;
    out_data.invalid_header_count = ser_r.bad_hdr;
    case (ser_idx_r)
      3'd0:    out_data.tx_byte = fcr_pkg::SYNC_A;
      3'd1:    out_data.tx_byte = fcr_pkg::SYNC_B;
      3'd2:    out_data.tx_byte = ser_r.hdr;
      3'd3:    out_data.tx_byte = ser_r.d0;
      3'd4:    out_data.tx_byte = ser_r.d1;
      3'd5:    out_data.tx_byte = ser_r.d2;
      3'd6:    out_data.tx_byte = ser_r.d3;
      default: out_data.tx_byte = ser_r.sum;
    endcase
    if (!ser_r.reply) begin
      out_data.tx_byte = 8'd0;
    end
  end

endmodule
